// ===== hdl/pvsb_pkg.sv =====
// Shared types, constants and saturating helpers for the particle Verlet step block.
package pvsb_pkg;

	localparam int PVSB_PLANETS = 4;

	// Fixed field widths
	localparam int VAL_W    = 64;
	localparam int MASS_W   = 63;
	localparam int DT_W     = 32;
	localparam int PCNT_W   = 3;
	localparam int SLOT_W   = 2;
	localparam int WIDE_W   = 128;
	localparam int FRAC_W   = 24;
	localparam int DNUM_W   = VAL_W + FRAC_W;
	localparam int ITER_W   = 7;
	localparam int T_W      = FRAC_W + 1;
	localparam int S_DATA_W = 640;
	localparam int M_DATA_W = 392;

	localparam logic [ITER_W-1:0] DIV_Q_STEPS = ITER_W'(DNUM_W);
	localparam logic [ITER_W-1:0] DIV_T_STEPS = ITER_W'(FRAC_W);
	localparam logic [ITER_W-1:0] SQRT_STEPS  = ITER_W'(VAL_W);

	localparam logic [DT_W-1:0] DT_RESET = 32'd16777216;

	localparam logic signed [VAL_W-1:0] S64_MAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic signed [VAL_W-1:0] S64_MIN = {1'b1, {(VAL_W-1){1'b0}}};

	// Register indexes
	localparam logic REG_DT           = 1'b0;
	localparam logic REG_PLANET_COUNT = 1'b1;

	// Operation codes
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_STEP = 1'b1;

	// Rounding shift of a product
	typedef enum logic [1:0] {
		SH_23,
		SH_24,
		SH_25
	} sh_sel_t;

	function automatic logic [VAL_W-1:0] f_mag(input logic signed [VAL_W-1:0] a);
		return a[VAL_W-1] ? (~a + 64'd1) : a;
	endfunction

	function automatic logic signed [VAL_W-1:0] f_sat_add(input logic signed [VAL_W-1:0] a,
		input logic signed [VAL_W-1:0] b);
		logic [VAL_W:0] s;
		s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
		if (s[VAL_W] != s[VAL_W-1]) begin
			return s[VAL_W] ? S64_MIN : S64_MAX;
		end
		return s[VAL_W-1:0];
	endfunction

	function automatic logic signed [VAL_W-1:0] f_sat_sub(input logic signed [VAL_W-1:0] a,
		input logic signed [VAL_W-1:0] b);
		logic [VAL_W:0] s;
		s = {a[VAL_W-1], a} - {b[VAL_W-1], b};
		if (s[VAL_W] != s[VAL_W-1]) begin
			return s[VAL_W] ? S64_MIN : S64_MAX;
		end
		return s[VAL_W-1:0];
	endfunction

	// Apply sign to a magnitude and clamp to the signed 64-bit range
	function automatic logic signed [VAL_W-1:0] f_pack(input logic neg,
		input logic [WIDE_W-1:0] m);
		if (!neg) begin
			if (m[WIDE_W-1:VAL_W-1] != '0) return S64_MAX;
			return m[VAL_W-1:0];
		end
		if (m[WIDE_W-1:VAL_W-1] != '0) return S64_MIN;
		return -m[VAL_W-1:0];
	endfunction

endpackage

// ===== hdl/pvsb_mul.sv =====
// Multi-cycle 64x64 magnitude multiplier with rounding shift and saturation.
module pvsb_mul import pvsb_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [VAL_W-1:0] a,
	input  logic signed [VAL_W-1:0] b,
	input  sh_sel_t                 sh,
	output logic                    done,
	output logic [WIDE_W-1:0]       prod,
	output logic signed [VAL_W-1:0] res
);

	logic [VAL_W-1:0]        am_q, bm_q;
	logic                    neg_q;
	sh_sel_t                 sh_q;
	logic [2:0]              cnt_q;
	logic                    busy_q, done_q, ppv_s1;
	logic [VAL_W-1:0]        pp_s1;
	logic [1:0]              sel_s1;
	logic [WIDE_W-1:0]       acc_q, pp_ext, sum, rnd;
	logic signed [VAL_W-1:0] res_q;
	logic [31:0]             ah, bh;

	assign ah = cnt_q[1] ? am_q[63:32] : am_q[31:0];
	assign bh = cnt_q[0] ? bm_q[63:32] : bm_q[31:0];

	// Place partial product by its half indexes
	always_comb begin
		case (sel_s1)
			2'd0:    pp_ext = WIDE_W'(pp_s1);
			2'd3:    pp_ext = WIDE_W'(pp_s1) << 64;
			default: pp_ext = WIDE_W'(pp_s1) << 32;
		endcase
	end

	// Round half away from zero on the magnitude, then shift
	always_comb begin
		case (sh_q)
			SH_23: begin
				sum = acc_q + (WIDE_W'(1) << 22);
				rnd = sum >> 23;
			end
			SH_25: begin
				sum = acc_q + (WIDE_W'(1) << 24);
				rnd = sum >> 25;
			end
			default: begin
				sum = acc_q + (WIDE_W'(1) << 23);
				rnd = sum >> 24;
			end
		endcase
	end

	// Sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			ppv_s1 <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			ppv_s1 <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (!cnt_q[2]) begin
					ppv_s1 <= 1'b1;
				end
				if (cnt_q == 3'd5) begin
					done_q <= 1'b1;
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Operands, partial products and accumulation
	always_ff @(posedge clk) begin
		if (start) begin
			am_q  <= f_mag(a);
			bm_q  <= f_mag(b);
			neg_q <= a[VAL_W-1] ^ b[VAL_W-1];
			sh_q  <= sh;
			acc_q <= '0;
		end else if (busy_q) begin
			if (!cnt_q[2]) begin
				pp_s1  <= ah * bh;
				sel_s1 <= cnt_q[1:0];
			end
			if (ppv_s1) begin
				acc_q <= acc_q + pp_ext;
			end
			if (cnt_q == 3'd5) begin
				res_q <= f_pack(neg_q, rnd);
			end
		end
	end

	assign done = done_q;
	assign prod = acc_q;
	assign res  = res_q;

endmodule

// ===== hdl/pvsb_div.sv =====
// Restoring divider, one quotient bit per cycle, with a preset remainder.
module pvsb_div import pvsb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [WIDE_W-1:0] rem_init,
	input  logic [DNUM_W-1:0] num,
	input  logic [WIDE_W-1:0] den,
	input  logic [ITER_W-1:0] iters,
	output logic              done,
	output logic [DNUM_W-1:0] quo
);

	logic [WIDE_W-1:0] rem_q, den_q;
	logic [DNUM_W-1:0] num_q, quo_q;
	logic [ITER_W-1:0] cnt_q;
	logic              busy_q, done_q, ge;
	logic [WIDE_W:0]   shv, diff;

	assign shv  = {rem_q, num_q[DNUM_W-1]};
	assign ge   = shv >= {1'b0, den_q};
	assign diff = shv - {1'b0, den_q};

	// Step count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= iters;
			end else if (busy_q) begin
				cnt_q <= cnt_q - ITER_W'(1);
				if (cnt_q == ITER_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift in one numerator bit, subtract when it fits
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= rem_init;
			num_q <= num;
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[WIDE_W-1:0] : shv[WIDE_W-1:0];
			num_q <= num_q << 1;
			quo_q <= {quo_q[DNUM_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

// ===== hdl/pvsb_sqrt.sv =====
// Floor square root of a 128-bit value, one root bit per cycle.
module pvsb_sqrt import pvsb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [WIDE_W-1:0] v,
	output logic              done,
	output logic [VAL_W-1:0]  root
);

	logic [WIDE_W-1:0] v_q;
	logic [VAL_W+1:0]  rem_q;
	logic [VAL_W-1:0]  root_q;
	logic [ITER_W-1:0] cnt_q;
	logic              busy_q, done_q, ge;
	logic [VAL_W+3:0]  shv, trial, diff;

	assign shv   = {rem_q, v_q[WIDE_W-1:WIDE_W-2]};
	assign trial = {2'b00, root_q, 2'b01};
	assign ge    = shv >= trial;
	assign diff  = shv - trial;

	// Step count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= SQRT_STEPS;
			end else if (busy_q) begin
				cnt_q <= cnt_q - ITER_W'(1);
				if (cnt_q == ITER_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Bring down two bits, try the next root bit
	always_ff @(posedge clk) begin
		if (start) begin
			v_q    <= v;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			v_q    <= v_q << 2;
			rem_q  <= ge ? diff[VAL_W+1:0] : shv[VAL_W+1:0];
			root_q <= {root_q[VAL_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// ===== hdl/particle_verlet_step_with_bounce_unit.sv =====
// Particle velocity-Verlet step with planet bounce: sequencer, tables and shared units.
//
// Input stream (s_*): one beat per operation. s_tuser selects a planet load or a
// particle step. A load writes one planet slot and gives no output beat. A step
// gives exactly one output beat (m_*) with the new position, velocity,
// acceleration and the bounced flag.
// Configuration: cfg_we writes the step size dt (index 0) or planet_count (index 1);
// write only while the block is idle.
// Items are handled one at a time. A step's work grows with each checked planet
// (more when the projection needs a division) and with each bounce. The cost is set
// by the shared restoring divider (force/mass, normal and projection divisions), the
// square root unit (lengths) and the four-pass multiplier (products).
// Reset clears the sequencer, the output valid and the configuration registers
// (dt = 1.0, planet_count = 0); planet slots are undefined until loaded.
// A stalled receiver holds the output beat; the block still accepts the next
// item and computes it, then waits before its own result is placed.
module particle_verlet_step_with_bounce_unit import pvsb_pkg::*; #(
	parameter int PLANETS = PVSB_PLANETS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [DT_W-1:0]     cfg_data,
	input  logic                s_tvalid,
	output logic                s_tready,
	// planet_index[1:0], pos_x, pos_y, vel_x, vel_y, acc_x, acc_y, force_x,
	// force_y (64 each), mass[62:0], planet_radius[62:0]
	input  logic [S_DATA_W-1:0] s_tdata,
	// operation
	input  logic [0:0]          s_tuser,
	output logic                m_tvalid,
	input  logic                m_tready,
	// new_pos_x, new_pos_y, new_vel_x, new_vel_y, new_acc_x, new_acc_y (64 each),
	// bounced, zero fill
	output logic [M_DATA_W-1:0] m_tdata
);

	localparam int IDX_W = (PLANETS > 1) ? $clog2(PLANETS) : 1;
	localparam int CNT_W = $clog2(PLANETS + 1);

	typedef enum logic [5:0] {
		S_IDLE, S_DT2, S_AX, S_AY, S_HX, S_HY, S_PVX, S_PVY, S_VVX, S_VVY,
		S_LOOP, S_SEG0, S_DD1, S_DD2, S_PX1, S_PY1, S_TSEL, S_TSEL2, S_TD,
		S_QX, S_QY, S_L1, S_L2, S_SQ, S_CMP, S_UPREP, S_NX, S_NY,
		S_D1, S_D2, S_R1, S_R2, S_P1, S_P2, S_OUT
	} state_t;

	state_t state_q;

	logic [DT_W-1:0]   dt_cfg_q;
	logic [PCNT_W-1:0] planet_count_q;

	logic signed [VAL_W-1:0] tab_x_q [PLANETS];
	logic signed [VAL_W-1:0] tab_y_q [PLANETS];
	logic [MASS_W-1:0]       tab_r_q [PLANETS];

	logic                    issued_q, bphase_q, bounced_q, gt_q, m_tvalid_q;
	logic [CNT_W-1:0]        i_q, lim_q;
	logic [IDX_W-1:0]        i_idx;
	logic signed [VAL_W-1:0] px_q, py_q, vx_q, vy_q, ox_q, oy_q, fx_q, fy_q;
	logic [MASS_W-1:0]       mass_q;
	logic signed [VAL_W-1:0] dt2_q, ax_q, ay_q, hx_q, hy_q;
	logic signed [VAL_W-1:0] npx_q, npy_q, nvx_q, nvy_q;
	logic signed [VAL_W-1:0] dx_q, dy_q, wx_q, wy_q, ex_q, ey_q, tmp_q, nx_q, ny_q;
	logic [VAL_W-1:0]        root_q;
	logic [T_W-1:0]          t_q;
	logic [WIDE_W-1:0]       acc_q, dd_q, pos_q, neg_q, r_q;
	logic [M_DATA_W-1:0]     out_q;

	logic signed [VAL_W-1:0] dt, tsx, cx, cy;
	logic                    in_acc, unit_done;

	logic                    mul_start, mul_done;
	logic signed [VAL_W-1:0] mul_a, mul_b, mul_res;
	sh_sel_t                 mul_sh;
	logic [WIDE_W-1:0]       mul_prod;

	logic                    div_start, div_done;
	logic [WIDE_W-1:0]       div_rem, div_den;
	logic [DNUM_W-1:0]       div_num, div_quo;
	logic [ITER_W-1:0]       div_iters;

	logic                    sq_start, sq_done;
	logic [VAL_W-1:0]        sq_root;

	assign dt        = signed'({{(VAL_W-DT_W){1'b0}}, dt_cfg_q});
	assign tsx       = signed'({{(VAL_W-T_W){1'b0}}, t_q});
	assign i_idx     = i_q[IDX_W-1:0];
	assign cx        = tab_x_q[i_idx];
	assign cy        = tab_y_q[i_idx];
	assign s_tready  = (state_q == S_IDLE);
	assign in_acc    = s_tvalid && s_tready;
	assign unit_done = mul_done || div_done || sq_done;

	pvsb_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.sh     (mul_sh),
		.done   (mul_done),
		.prod   (mul_prod),
		.res    (mul_res)
	);

	pvsb_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.rem_init (div_rem),
		.num      (div_num),
		.den      (div_den),
		.iters    (div_iters),
		.done     (div_done),
		.quo      (div_quo)
	);

	pvsb_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.v      (acc_q),
		.done   (sq_done),
		.root   (sq_root)
	);

	// Route operands to the shared units for the current step
	always_comb begin
		mul_start = 1'b0;
		div_start = 1'b0;
		sq_start  = 1'b0;
		mul_a     = dt;
		mul_b     = dt;
		mul_sh    = SH_24;
		div_rem   = '0;
		div_num   = '0;
		div_den   = '0;
		div_iters = DIV_Q_STEPS;
		unique case (state_q)
			S_DT2: mul_start = !issued_q;
			S_AX: begin
				div_start = !issued_q;
				div_num   = {f_mag(fx_q), {FRAC_W{1'b0}}};
				div_den   = WIDE_W'(mass_q);
			end
			S_AY: begin
				div_start = !issued_q;
				div_num   = {f_mag(fy_q), {FRAC_W{1'b0}}};
				div_den   = WIDE_W'(mass_q);
			end
			S_HX: begin
				mul_start = !issued_q;
				mul_a     = ox_q;
				mul_b     = dt2_q;
				mul_sh    = SH_25;
			end
			S_HY: begin
				mul_start = !issued_q;
				mul_a     = oy_q;
				mul_b     = dt2_q;
				mul_sh    = SH_25;
			end
			S_PVX, S_P1: begin
				mul_start = !issued_q;
				mul_a     = (state_q == S_PVX) ? vx_q : nvx_q;
			end
			S_PVY, S_P2: begin
				mul_start = !issued_q;
				mul_a     = (state_q == S_PVY) ? vy_q : nvy_q;
			end
			S_VVX: begin
				mul_start = !issued_q;
				mul_a     = f_sat_add(ox_q, ax_q);
				mul_sh    = SH_25;
			end
			S_VVY: begin
				mul_start = !issued_q;
				mul_a     = f_sat_add(oy_q, ay_q);
				mul_sh    = SH_25;
			end
			S_DD1: begin
				mul_start = !issued_q;
				mul_a     = dx_q;
				mul_b     = dx_q;
			end
			S_DD2: begin
				mul_start = !issued_q;
				mul_a     = dy_q;
				mul_b     = dy_q;
			end
			S_PX1: begin
				mul_start = !issued_q;
				mul_a     = wx_q;
				mul_b     = dx_q;
			end
			S_PY1: begin
				mul_start = !issued_q;
				mul_a     = wy_q;
				mul_b     = dy_q;
			end
			S_TD: begin
				div_start = !issued_q;
				div_rem   = r_q;
				div_den   = dd_q;
				div_iters = DIV_T_STEPS;
			end
			S_QX: begin
				mul_start = !issued_q;
				mul_a     = dx_q;
				mul_b     = tsx;
			end
			S_QY: begin
				mul_start = !issued_q;
				mul_a     = dy_q;
				mul_b     = tsx;
			end
			S_L1: begin
				mul_start = !issued_q;
				mul_a     = ex_q;
				mul_b     = ex_q;
			end
			S_L2: begin
				mul_start = !issued_q;
				mul_a     = ey_q;
				mul_b     = ey_q;
			end
			S_SQ: sq_start = !issued_q;
			S_NX: begin
				div_start = !issued_q;
				div_num   = {f_mag(ex_q), {FRAC_W{1'b0}}};
				div_den   = WIDE_W'(root_q);
			end
			S_NY: begin
				div_start = !issued_q;
				div_num   = {f_mag(ey_q), {FRAC_W{1'b0}}};
				div_den   = WIDE_W'(root_q);
			end
			S_D1: begin
				mul_start = !issued_q;
				mul_a     = nx_q;
				mul_b     = nvx_q;
			end
			S_D2: begin
				mul_start = !issued_q;
				mul_a     = ny_q;
				mul_b     = nvy_q;
			end
			S_R1: begin
				mul_start = !issued_q;
				mul_a     = tmp_q;
				mul_b     = nx_q;
				mul_sh    = SH_23;
			end
			S_R2: begin
				mul_start = !issued_q;
				mul_a     = tmp_q;
				mul_b     = ny_q;
				mul_sh    = SH_23;
			end
			default: ;
		endcase
	end

	// Planet slots: written by a load beat
	always_ff @(posedge clk) begin
		if (in_acc && s_tuser[0] == OP_LOAD && 32'(s_tdata[1:0]) < PLANETS) begin
			tab_x_q[IDX_W'(s_tdata[1:0])] <= s_tdata[65:2];
			tab_y_q[IDX_W'(s_tdata[1:0])] <= s_tdata[129:66];
			tab_r_q[IDX_W'(s_tdata[1:0])] <= s_tdata[639:577];
		end
	end

	// Sequencer: state, configuration and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			issued_q       <= 1'b0;
			m_tvalid_q     <= 1'b0;
			dt_cfg_q       <= DT_RESET;
			planet_count_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_DT:           dt_cfg_q       <= cfg_data;
					REG_PLANET_COUNT: planet_count_q <= cfg_data[PCNT_W-1:0];
					default: ;
				endcase
			end
			if (unit_done) begin
				issued_q <= 1'b0;
			end else if (mul_start || div_start || sq_start) begin
				issued_q <= 1'b1;
			end
			// Raise valid when a result is placed, drop it once taken
			if (state_q == S_OUT && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc && s_tuser[0] == OP_STEP) begin
						px_q      <= s_tdata[65:2];
						py_q      <= s_tdata[129:66];
						vx_q      <= s_tdata[193:130];
						vy_q      <= s_tdata[257:194];
						ox_q      <= s_tdata[321:258];
						oy_q      <= s_tdata[385:322];
						fx_q      <= s_tdata[449:386];
						fy_q      <= s_tdata[513:450];
						mass_q    <= s_tdata[576:514];
						i_q       <= '0;
						bounced_q <= 1'b0;
						lim_q     <= (32'(planet_count_q) < PLANETS) ?
							CNT_W'(planet_count_q) : CNT_W'(PLANETS);
						state_q   <= S_DT2;
					end
				end
				S_DT2: if (unit_done) begin
					dt2_q   <= mul_res;
					state_q <= S_AX;
				end
				S_AX: if (unit_done) begin
					ax_q    <= (mass_q == '0) ? '0 : f_pack(fx_q[VAL_W-1], WIDE_W'(div_quo));
					state_q <= S_AY;
				end
				S_AY: if (unit_done) begin
					ay_q    <= (mass_q == '0) ? '0 : f_pack(fy_q[VAL_W-1], WIDE_W'(div_quo));
					state_q <= S_HX;
				end
				S_HX: if (unit_done) begin
					hx_q    <= mul_res;
					state_q <= S_HY;
				end
				S_HY: if (unit_done) begin
					hy_q    <= mul_res;
					state_q <= S_PVX;
				end
				S_PVX: if (unit_done) begin
					npx_q   <= f_sat_add(f_sat_add(px_q, mul_res), hx_q);
					state_q <= S_PVY;
				end
				S_PVY: if (unit_done) begin
					npy_q   <= f_sat_add(f_sat_add(py_q, mul_res), hy_q);
					state_q <= S_VVX;
				end
				S_VVX: if (unit_done) begin
					nvx_q   <= f_sat_add(vx_q, mul_res);
					state_q <= S_VVY;
				end
				S_VVY: if (unit_done) begin
					nvy_q   <= f_sat_add(vy_q, mul_res);
					state_q <= S_LOOP;
				end
				S_LOOP: begin
					state_q <= (i_q < lim_q) ? S_SEG0 : S_OUT;
				end
				// Segment and planet offsets from the old position
				S_SEG0: begin
					dx_q     <= f_sat_sub(npx_q, px_q);
					dy_q     <= f_sat_sub(npy_q, py_q);
					wx_q     <= f_sat_sub(cx, px_q);
					wy_q     <= f_sat_sub(cy, py_q);
					bphase_q <= 1'b0;
					state_q  <= S_DD1;
				end
				S_DD1: if (unit_done) begin
					acc_q   <= mul_prod;
					state_q <= S_DD2;
				end
				S_DD2: if (unit_done) begin
					dd_q    <= acc_q + mul_prod;
					state_q <= S_PX1;
				end
				S_PX1: if (unit_done) begin
					if (wx_q[VAL_W-1] == dx_q[VAL_W-1]) begin
						pos_q <= mul_prod;
						neg_q <= '0;
					end else begin
						pos_q <= '0;
						neg_q <= mul_prod;
					end
					state_q <= S_PY1;
				end
				S_PY1: if (unit_done) begin
					if (wy_q[VAL_W-1] == dy_q[VAL_W-1]) begin
						pos_q <= pos_q + mul_prod;
					end else begin
						neg_q <= neg_q + mul_prod;
					end
					state_q <= S_TSEL;
				end
				S_TSEL: begin
					r_q     <= pos_q - neg_q;
					gt_q    <= pos_q > neg_q;
					state_q <= S_TSEL2;
				end
				// Clamp the projection to the segment ends
				S_TSEL2: begin
					if (dd_q == '0 || !gt_q) begin
						t_q     <= '0;
						state_q <= S_QX;
					end else if (r_q >= dd_q) begin
						t_q     <= T_W'(1) << FRAC_W;
						state_q <= S_QX;
					end else begin
						state_q <= S_TD;
					end
				end
				S_TD: if (unit_done) begin
					t_q     <= {1'b0, div_quo[FRAC_W-1:0]};
					state_q <= S_QX;
				end
				S_QX: if (unit_done) begin
					ex_q    <= f_sat_sub(cx, f_sat_add(px_q, mul_res));
					state_q <= S_QY;
				end
				S_QY: if (unit_done) begin
					ey_q    <= f_sat_sub(cy, f_sat_add(py_q, mul_res));
					state_q <= S_L1;
				end
				S_L1: if (unit_done) begin
					acc_q   <= mul_prod;
					state_q <= S_L2;
				end
				S_L2: if (unit_done) begin
					acc_q   <= acc_q + mul_prod;
					state_q <= S_SQ;
				end
				S_SQ: if (unit_done) begin
					root_q  <= sq_root;
					state_q <= bphase_q ? S_NX : S_CMP;
				end
				S_CMP: begin
					if ({1'b0, tab_r_q[i_idx]} >= root_q) begin
						state_q <= S_UPREP;
					end else begin
						i_q     <= i_q + CNT_W'(1);
						state_q <= S_LOOP;
					end
				end
				// Normal from the old position to the planet center
				S_UPREP: begin
					ex_q     <= f_sat_sub(cx, px_q);
					ey_q     <= f_sat_sub(cy, py_q);
					bphase_q <= 1'b1;
					state_q  <= S_L1;
				end
				S_NX: if (unit_done) begin
					nx_q    <= (root_q == '0) ? '0 : f_pack(ex_q[VAL_W-1], WIDE_W'(div_quo));
					state_q <= S_NY;
				end
				S_NY: if (unit_done) begin
					ny_q    <= (root_q == '0) ? '0 : f_pack(ey_q[VAL_W-1], WIDE_W'(div_quo));
					state_q <= S_D1;
				end
				S_D1: if (unit_done) begin
					tmp_q   <= mul_res;
					state_q <= S_D2;
				end
				S_D2: if (unit_done) begin
					tmp_q   <= f_sat_add(tmp_q, mul_res);
					state_q <= S_R1;
				end
				S_R1: if (unit_done) begin
					nvx_q   <= f_sat_sub(nvx_q, mul_res);
					state_q <= S_R2;
				end
				S_R2: if (unit_done) begin
					nvy_q   <= f_sat_sub(nvy_q, mul_res);
					state_q <= S_P1;
				end
				S_P1: if (unit_done) begin
					npx_q   <= f_sat_add(f_sat_add(px_q, mul_res), hx_q);
					state_q <= S_P2;
				end
				S_P2: if (unit_done) begin
					npy_q     <= f_sat_add(f_sat_add(py_q, mul_res), hy_q);
					ax_q      <= '0;
					ay_q      <= '0;
					bounced_q <= 1'b1;
					i_q       <= i_q + CNT_W'(1);
					state_q   <= S_LOOP;
				end
				// Place the result once the output register is free
				S_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						out_q   <= {7'd0, bounced_q, ay_q, ax_q, nvy_q, nvx_q, npy_q, npx_q};
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_q;

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the particle Verlet step unit with planet bounce.
`timescale 1ns / 1ps

module testbench;
	import pvsb_pkg::*;

	typedef logic [127:0] u128_t;
	typedef logic signed [63:0] s64_t;

	typedef struct {
		logic       op;
		logic [1:0] idx;
		s64_t       px, py, vx, vy, ax, ay, fx, fy;
		logic [62:0] mass;
		logic [62:0] radius;
	} particle_item_t;

	typedef struct {
		s64_t px, py, vx, vy, ax, ay;
		logic bnc;
	} motion_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic                cfg_index;
	logic [DT_W-1:0]     cfg_data;
	logic                s_tvalid;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata;
	logic [0:0]          s_tuser;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;

	// Shadow of the configuration and the planet table
	logic [DT_W-1:0]   dt_q;
	logic [PCNT_W-1:0] pcnt_q;
	s64_t              tbl_x [PVSB_PLANETS];
	s64_t              tbl_y [PVSB_PLANETS];
	s64_t              tbl_r [PVSB_PLANETS];

	motion_t motion_q[$];
	int      err_cnt = 0;
	int      idle_pct = 0;
	int      stall_pct = 0;
	int      hold_seq = 0;
	int      hold_seen = 0;
	int      hold_left = 0;

	particle_verlet_step_with_bounce_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// ---------------- fixed-point arithmetic ----------------

	function automatic logic [63:0] fx_mag(s64_t a);
		return a[63] ? (~a + 64'd1) : a;
	endfunction

	function automatic s64_t fx_pack(logic neg, u128_t m);
		if (m > u128_t'(64'h7FFF_FFFF_FFFF_FFFF)) return neg ? S64_MIN : S64_MAX;
		return neg ? -s64_t'(m[63:0]) : s64_t'(m[63:0]);
	endfunction

	function automatic s64_t fx_add(s64_t a, s64_t b);
		logic signed [64:0] s;
		s = 65'(a) + 65'(b);
		if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return S64_MAX;
		if (s < -65'sh0_8000_0000_0000_0000) return S64_MIN;
		return s[63:0];
	endfunction

	function automatic s64_t fx_sub(s64_t a, s64_t b);
		logic signed [64:0] s;
		s = 65'(a) - 65'(b);
		if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return S64_MAX;
		if (s < -65'sh0_8000_0000_0000_0000) return S64_MIN;
		return s[63:0];
	endfunction

	// Rounded product scaled down by 2^sh, ties away from zero
	function automatic s64_t fx_mul(s64_t a, s64_t b, int sh);
		u128_t m;
		m = u128_t'(fx_mag(a)) * u128_t'(fx_mag(b));
		m = (m + (u128_t'(1) << (sh - 1))) >> sh;
		return fx_pack(a[63] != b[63], m);
	endfunction

	// Q24 quotient, truncated toward zero
	function automatic s64_t fx_div(s64_t a, logic [63:0] d);
		u128_t num;
		if (d == 64'd0) return '0;
		num = u128_t'(fx_mag(a)) << 24;
		return fx_pack(a[63], num / u128_t'(d));
	endfunction

	function automatic logic [63:0] floor_root(u128_t v);
		logic [63:0] r, c;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			c = r | (64'd1 << b);
			if (u128_t'(c) * u128_t'(c) <= v) r = c;
		end
		return r;
	endfunction

	function automatic logic [63:0] vec_len(s64_t x, s64_t y);
		return floor_root(u128_t'(fx_mag(x)) * fx_mag(x) + u128_t'(fx_mag(y)) * fx_mag(y));
	endfunction

	// Distance from a planet centre to the segment p0..p1
	function automatic logic [63:0] seg_gap(s64_t p0x, s64_t p0y, s64_t p1x, s64_t p1y,
		s64_t cx, s64_t cy);
		s64_t        dx, dy, wx, wy, t;
		u128_t       dd, pos_acc, neg_acc, prx, pry, r;
		logic [151:0] wide;
		dx = fx_sub(p1x, p0x);
		dy = fx_sub(p1y, p0y);
		wx = fx_sub(cx, p0x);
		wy = fx_sub(cy, p0y);
		dd = u128_t'(fx_mag(dx)) * fx_mag(dx) + u128_t'(fx_mag(dy)) * fx_mag(dy);
		prx = u128_t'(fx_mag(wx)) * fx_mag(dx);
		pry = u128_t'(fx_mag(wy)) * fx_mag(dy);
		pos_acc = '0;
		neg_acc = '0;
		t = '0;
		if (wx[63] == dx[63]) pos_acc += prx; else neg_acc += prx;
		if (wy[63] == dy[63]) pos_acc += pry; else neg_acc += pry;
		if (dd != '0 && pos_acc > neg_acc) begin
			r = pos_acc - neg_acc;
			if (r >= dd) begin
				t = 64'sd1 << 24;
			end else begin
				wide = 152'(r) << 24;
				t = s64_t'(wide / 152'(dd));
			end
		end
		return vec_len(fx_sub(cx, fx_add(p0x, fx_mul(dx, t, 24))),
			fx_sub(cy, fx_add(p0y, fx_mul(dy, t, 24))));
	endfunction

	// Apply one item to the shadow state and queue the motion it must produce
	function automatic void model_item(particle_item_t it);
		s64_t        dt, dt2, hx, hy, ax, ay, npx, npy, nvx, nvy;
		s64_t        ux, uy, nx, ny, dot;
		logic [63:0] len;
		int          cnt;
		motion_t     res;
		if (it.op == OP_LOAD) begin
			tbl_x[it.idx] = it.px;
			tbl_y[it.idx] = it.py;
			tbl_r[it.idx] = s64_t'({1'b0, it.radius});
			return;
		end
		dt = s64_t'({32'd0, dt_q});
		dt2 = fx_mul(dt, dt, 24);
		ax = fx_div(it.fx, {1'b0, it.mass});
		ay = fx_div(it.fy, {1'b0, it.mass});
		hx = fx_mul(it.ax, dt2, 25);
		hy = fx_mul(it.ay, dt2, 25);
		npx = fx_add(fx_add(it.px, fx_mul(it.vx, dt, 24)), hx);
		npy = fx_add(fx_add(it.py, fx_mul(it.vy, dt, 24)), hy);
		nvx = fx_add(it.vx, fx_mul(fx_add(it.ax, ax), dt, 25));
		nvy = fx_add(it.vy, fx_mul(fx_add(it.ay, ay), dt, 25));
		res.bnc = 1'b0;
		cnt = (pcnt_q < PVSB_PLANETS) ? int'(pcnt_q) : PVSB_PLANETS;
		for (int i = 0; i < cnt; i++) begin
			if (tbl_r[i] >= seg_gap(it.px, it.py, npx, npy, tbl_x[i], tbl_y[i])) begin
				ux = fx_sub(tbl_x[i], it.px);
				uy = fx_sub(tbl_y[i], it.py);
				len = vec_len(ux, uy);
				nx = fx_div(ux, len);
				ny = fx_div(uy, len);
				dot = fx_add(fx_mul(nx, nvx, 24), fx_mul(ny, nvy, 24));
				nvx = fx_sub(nvx, fx_mul(dot, nx, 23));
				nvy = fx_sub(nvy, fx_mul(dot, ny, 23));
				npx = fx_add(fx_add(it.px, fx_mul(nvx, dt, 24)), hx);
				npy = fx_add(fx_add(it.py, fx_mul(nvy, dt, 24)), hy);
				ax = '0;
				ay = '0;
				res.bnc = 1'b1;
			end
		end
		res.px = npx;
		res.py = npy;
		res.vx = nvx;
		res.vy = nvy;
		res.ax = ax;
		res.ay = ay;
		motion_q = {motion_q, res};
	endfunction

	// ---------------- drivers ----------------

	// Send one beat, with random idle cycles ahead of it
	task automatic send_item(particle_item_t it);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= it.op;
		s_tdata  <= {it.radius, it.mass, it.fy, it.fx, it.ay, it.ax, it.vy, it.vx,
			it.py, it.px, it.idx};
		model_item(it);
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic finish_sends();
		s_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	// Drain all expected beats, then let a trailing load settle
	task automatic wait_idle();
		finish_sends();
		while (motion_q.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [DT_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		if (idx == REG_DT) dt_q = val;
		else pcnt_q = val[PCNT_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// ---------------- stimulus helpers ----------------

	function automatic s64_t rand_s64();
		return {$urandom, $urandom};
	endfunction

	// Whole part within +/- units, plus a random fraction (Q40.24)
	function automatic s64_t near_val(int unsigned units);
		s64_t w;
		w = s64_t'($urandom_range(0, 2 * units)) - s64_t'(units);
		return (w <<< 24) + s64_t'($urandom_range(0, 24'hFF_FFFF));
	endfunction

	function automatic particle_item_t blank_step();
		particle_item_t it;
		it.op = OP_STEP;
		it.idx = '0;
		it.px = '0; it.py = '0; it.vx = '0; it.vy = '0;
		it.ax = '0; it.ay = '0; it.fx = '0; it.fy = '0;
		it.mass = 63'd1 << 24;
		it.radius = '0;
		return it;
	endfunction

	function automatic particle_item_t planet_load(logic [1:0] idx, int unsigned spread,
		int unsigned rmax);
		particle_item_t it;
		it = blank_step();
		it.op = OP_LOAD;
		it.idx = idx;
		it.px = near_val(spread);
		it.py = near_val(spread);
		it.vx = rand_s64();
		it.fy = rand_s64();
		it.mass = 63'({$urandom, $urandom});
		it.radius = (63'($urandom_range(1, rmax)) << 24) + 63'($urandom_range(0, 24'hFF_FFFF));
		return it;
	endfunction

	// Mostly particles aimed at a planet, some loose ones, some full-range noise, and occasional planet loads
	function automatic particle_item_t random_item();
		particle_item_t it;
		int             r, j;
		r = $urandom_range(99);
		it = blank_step();
		it.idx = 2'($urandom);
		if (r < 5) begin
			it = planet_load(2'($urandom), 50, 20);
			if ($urandom_range(19) == 0) it.radius = 63'({$urandom, $urandom});
		end else if (r < 65) begin
			j = $urandom_range(0, PVSB_PLANETS - 1);
			it.px = fx_add(tbl_x[j], near_val(40));
			it.py = fx_add(tbl_y[j], near_val(40));
			it.vx = fx_add(fx_sub(tbl_x[j], it.px), near_val(4));
			it.vy = fx_add(fx_sub(tbl_y[j], it.py), near_val(4));
			it.ax = near_val(2);
			it.ay = near_val(2);
			it.fx = near_val(200);
			it.fy = near_val(200);
			it.mass = 63'($urandom_range(1, 64)) << 24;
		end else if (r < 88) begin
			it.px = near_val(100); it.py = near_val(100);
			it.vx = near_val(30);  it.vy = near_val(30);
			it.ax = near_val(10);  it.ay = near_val(10);
			it.fx = near_val(1000); it.fy = near_val(1000);
			it.mass = 63'($urandom_range(0, 1 << 30));
		end else begin
			it.px = rand_s64(); it.py = rand_s64();
			it.vx = rand_s64(); it.vy = rand_s64();
			it.ax = rand_s64(); it.ay = rand_s64();
			it.fx = rand_s64(); it.fy = rand_s64();
			it.mass = 63'({$urandom, $urandom});
		end
		if ($urandom_range(99) == 0) it.mass = '0;
		return it;
	endfunction

	// ---------------- receive side ----------------

	// Receiver stall: random, or a long hold-off when one is requested
	always @(posedge clk) begin
		if (hold_seq != hold_seen) begin
			hold_seen <= hold_seq;
			hold_left <= 6000;
			m_tready  <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic cmp_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %h, got %h", name, want, got);
			err_cnt++;
		end
	endtask

	// Compare each output beat with the oldest expected motion
	always @(posedge clk) begin
		motion_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (motion_q.size() == 0) begin
				$error("output beat with no step pending");
				err_cnt++;
			end else begin
				e = motion_q.pop_front();
				cmp_field("new_pos_x", e.px, m_tdata[63:0]);
				cmp_field("new_pos_y", e.py, m_tdata[127:64]);
				cmp_field("new_vel_x", e.vx, m_tdata[191:128]);
				cmp_field("new_vel_y", e.vy, m_tdata[255:192]);
				cmp_field("new_acc_x", e.ax, m_tdata[319:256]);
				cmp_field("new_acc_y", e.ay, m_tdata[383:320]);
				cmp_field("bounced", 64'(e.bnc), 64'(m_tdata[384]));
			end
		end
	end

	// ---------------- tests ----------------

	// Steps under reset configuration, then fill every planet slot
	task automatic test_reset_and_load();
		particle_item_t it;
		it = blank_step();
		it.px = near_val(10); it.vx = near_val(3); it.fy = near_val(50);
		send_item(it);
		it = blank_step();
		it.px = S64_MAX; it.py = S64_MIN; it.vx = S64_MAX; it.vy = S64_MIN;
		it.ax = S64_MAX; it.ay = S64_MIN; it.fx = S64_MAX; it.fy = S64_MIN;
		it.mass = 63'd1;
		send_item(it);
		it.px = S64_MIN; it.py = S64_MAX; it.vx = S64_MIN; it.vy = S64_MAX;
		it.ax = S64_MIN; it.ay = S64_MAX; it.fx = S64_MIN; it.fy = S64_MAX;
		it.mass = '1;
		send_item(it);
		// zero mass
		it = blank_step();
		it.fx = near_val(100); it.fy = near_val(100); it.mass = '0;
		send_item(it);
		// extreme planet entries, later overwritten by sane ones
		it = planet_load(2'd3, 10, 5);
		it.px = S64_MIN; it.py = S64_MAX; it.radius = '1;
		send_item(it);
		for (int i = 0; i < PVSB_PLANETS; i++) send_item(planet_load(2'(i), 50, 20));
		wait_idle();
	endtask

	// Special cases with all planets checked
	task automatic test_special_cases();
		particle_item_t it;
		write_reg(REG_PLANET_COUNT, 32'd4);
		// aimed straight at planet 0
		it = blank_step();
		it.px = fx_add(tbl_x[0], near_val(20));
		it.py = fx_add(tbl_y[0], near_val(20));
		it.vx = fx_sub(tbl_x[0], it.px);
		it.vy = fx_sub(tbl_y[0], it.py);
		send_item(it);
		// zero-length segment next to a planet
		it = blank_step();
		it.px = fx_add(tbl_x[1], 64'sd1 << 24);
		it.py = tbl_y[1];
		send_item(it);
		// zero-length normal: particle sits on a planet centre
		it = blank_step();
		it.px = tbl_x[2]; it.py = tbl_y[2];
		it.vx = near_val(3); it.vy = near_val(3);
		send_item(it);
		wait_idle();
		// count above the table size
		write_reg(REG_PLANET_COUNT, 32'd7);
		it.px = tbl_x[3]; it.py = tbl_y[3];
		send_item(it);
		wait_idle();
		// zero time step, then the largest
		write_reg(REG_DT, '0);
		it = blank_step();
		it.px = near_val(50); it.vx = near_val(10); it.ax = near_val(5); it.fx = near_val(9);
		send_item(it);
		wait_idle();
		write_reg(REG_DT, '1);
		send_item(it);
		it.vx = S64_MAX; it.ay = S64_MIN;
		send_item(it);
		wait_idle();
	endtask

	task automatic run_phase(int n, int idle, int stall, logic [DT_W-1:0] dt,
		logic [PCNT_W-1:0] cnt);
		write_reg(REG_DT, dt);
		write_reg(REG_PLANET_COUNT, DT_W'(cnt));
		idle_pct  = idle;
		stall_pct = stall;
		for (int i = 0; i < n; i++) send_item(random_item());
		wait_idle();
	endtask

	// Random traffic under every idling mix and several settings
	task automatic test_random_traffic();
		run_phase(500, 0, 0, 32'h0100_0000, 3'd4);
		run_phase(450, 71, 0, 32'h0080_0000, 3'd2);
		run_phase(450, 0, 71, 32'h0180_0000, 3'd4);
		run_phase(400, 12, 12, 32'h0100_0000, 3'd0);
		run_phase(150, 12, 12, 32'h0100_0000, 3'd7);
		run_phase(50, 0, 0, $urandom, 3'd4);
	endtask

	// Hold the receiver off while items keep coming so the input stalls
	task automatic test_backpressure();
		write_reg(REG_DT, 32'h0100_0000);
		write_reg(REG_PLANET_COUNT, 32'd1);
		idle_pct  = 0;
		stall_pct = 0;
		hold_seq++;
		for (int i = 0; i < 12; i++) send_item(random_item());
		wait_idle();
	endtask

	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = REG_DT;
		cfg_data  = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = OP_LOAD;
		dt_q      = DT_RESET;
		pcnt_q    = '0;
		for (int i = 0; i < PVSB_PLANETS; i++) begin
			tbl_x[i] = '0;
			tbl_y[i] = '0;
			tbl_r[i] = '0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_and_load();
		test_special_cases();
		test_random_traffic();
		test_backpressure();

		repeat (200) @(posedge clk);
		if (err_cnt == 0) begin
			$display("particle_verlet_step_with_bounce_unit regression: pass");
		end else begin
			$display("particle_verlet_step_with_bounce_unit regression: fail");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#200_000_000;
		$display("particle_verlet_step_with_bounce_unit regression: fail");
		$finish;
	end

endmodule

// ===== particle_verlet_step_with_bounce_unit.f =====
hdl/pvsb_pkg.sv
hdl/pvsb_mul.sv
hdl/pvsb_div.sv
hdl/pvsb_sqrt.sv
hdl/particle_verlet_step_with_bounce_unit.sv
tb/sv/testbench.sv
